// ===== design/crcfe_pkg.sv =====
// Package: shared constants, types and the CRC-32 byte update for the frame encoder.
`default_nettype none

package crcfe_pkg;

  localparam int unsigned MaxPayload = 4096;
  localparam int unsigned LenW       = 13;
  localparam int unsigned PaddrW     = 3;
  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned FifoPtrW   = $clog2(FifoDepth);
  localparam int unsigned FifoCntW   = $clog2(FifoDepth + 1);

  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;

  localparam logic RegMagic   = 1'b0;
  localparam logic RegVersion = 1'b1;

  typedef enum logic {
    OP_HEADER  = 1'b0,
    OP_PAYLOAD = 1'b1
  } op_e;

  typedef enum logic {
    CMD_HDR = 1'b0,
    CMD_PAY = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e       kind;
    logic [7:0]      frame_type;
    logic [31:0]     seq;
    logic [LenW-1:0] len;
    logic [7:0]      data;
    logic            last;
  } cmd_t;

  typedef struct packed {
    logic [15:0] magic;
    logic [7:0]  version;
  } cfg_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (c[0] ? CrcPoly : 32'd0);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/crcfe_if.sv =====
// Interfaces: request channel into the encoder and byte stream out of it.
`default_nettype none

interface crcfe_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [7:0]  frame_type;
  logic [31:0] sequence_number;
  logic [12:0] payload_length;
  logic [7:0]  payload_byte;

  modport source (output valid, operation, frame_type, sequence_number, payload_length,
                  payload_byte, input ready);
  modport sink (input valid, operation, frame_type, sequence_number, payload_length,
                payload_byte, output ready);
endinterface

interface crcfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_frame;

  modport source (output valid, out_byte, end_of_frame, input ready);
  modport sink (input valid, out_byte, end_of_frame, output ready);
endinterface

`default_nettype wire

// ===== design/crcfe_regs.sv =====
// Configuration registers behind the APB-style port.
`default_nettype none

module crcfe_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [crcfe_pkg::PaddrW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output crcfe_pkg::cfg_t                 cfg_o
);

  crcfe_pkg::cfg_t cfg_q;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      unique case (paddr[2])
        crcfe_pkg::RegMagic:   cfg_q.magic   <= pwdata[15:0];
        crcfe_pkg::RegVersion: cfg_q.version <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      crcfe_pkg::RegMagic:   prdata = {16'd0, cfg_q.magic};
      crcfe_pkg::RegVersion: prdata = {24'd0, cfg_q.version};
      default:               prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/crcfe_front.sv =====
// Front end: accept requests, track the open frame and queue commands for the serializer.
`default_nettype none

module crcfe_front (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  crcfe_in_if.sink         in_i,
  input  wire logic        fifo_full_i,
  output logic             push_o,
  output crcfe_pkg::cmd_t  cmd_o
);

  logic [crcfe_pkg::LenW-1:0] rem_q, rem_d;
  logic [crcfe_pkg::LenW-1:0] len_sat;
  logic                       accept;

  assign in_i.ready = !fifo_full_i;
  assign accept     = in_i.valid && in_i.ready;

  assign len_sat = (in_i.payload_length > crcfe_pkg::LenW'(crcfe_pkg::MaxPayload))
                   ? crcfe_pkg::LenW'(crcfe_pkg::MaxPayload) : in_i.payload_length;

  always_comb begin
    rem_d            = rem_q;
    push_o           = 1'b0;
    cmd_o.kind       = crcfe_pkg::CMD_HDR;
    cmd_o.frame_type = in_i.frame_type;
    cmd_o.seq        = in_i.sequence_number;
    cmd_o.len        = len_sat;
    cmd_o.data       = in_i.payload_byte;
    cmd_o.last       = (rem_q == crcfe_pkg::LenW'(1));
    if (accept) begin
      if (in_i.operation == crcfe_pkg::OP_HEADER) begin
        push_o = 1'b1;
        rem_d  = len_sat;
      end else if (rem_q != '0) begin
        push_o     = 1'b1;
        cmd_o.kind = crcfe_pkg::CMD_PAY;
        rem_d      = rem_q - crcfe_pkg::LenW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/crcfe_fifo.sv =====
// Command queue between the front end and the serializer.
`default_nettype none

module crcfe_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire crcfe_pkg::cmd_t  push_data_i,
  input  wire logic             pop_i,
  output crcfe_pkg::cmd_t       pop_data_o,
  output logic                  full_o,
  output logic                  empty_o
);

  crcfe_pkg::cmd_t                  mem_q [crcfe_pkg::FifoDepth];
  logic [crcfe_pkg::FifoPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [crcfe_pkg::FifoCntW-1:0]   cnt_q;
  logic                             do_push, do_pop;

  assign full_o     = (cnt_q == crcfe_pkg::FifoCntW'(crcfe_pkg::FifoDepth));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + crcfe_pkg::FifoPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + crcfe_pkg::FifoPtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + crcfe_pkg::FifoCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - crcfe_pkg::FifoCntW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= crcfe_pkg::FifoCntW'(crcfe_pkg::FifoDepth))
    else $error("queue count above depth");

endmodule

`default_nettype wire

// ===== design/crcfe_back.sv =====
// Back end: serialize queued commands into frame bytes with a running CRC-32.
`default_nettype none

module crcfe_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire crcfe_pkg::cfg_t  cfg_i,
  input  wire logic             fifo_empty_i,
  input  wire crcfe_pkg::cmd_t  pop_data_i,
  output logic                  pop_o,
  crcfe_out_if.source           out_o
);

  typedef enum logic [3:0] {
    StepMagicLo = 4'd0,
    StepMagicHi = 4'd1,
    StepVersion = 4'd2,
    StepType    = 4'd3,
    StepSeq0    = 4'd4,
    StepSeq1    = 4'd5,
    StepSeq2    = 4'd6,
    StepSeq3    = 4'd7,
    StepLenLo   = 4'd8,
    StepLenHi   = 4'd9,
    StepCrc0    = 4'd10,
    StepCrc1    = 4'd11,
    StepCrc2    = 4'd12,
    StepCrc3    = 4'd13,
    StepUnused  = 4'd14,
    StepPayload = 4'd15
  } step_e;

  crcfe_pkg::cmd_t cmd_q;
  logic            active_q;
  step_e           step_q, step_next;
  logic [31:0]     crc_q, crc_base, crc_inv;
  logic            out_valid_q, out_eof_q;
  logic [7:0]      out_byte_q, byte_sel;
  logic            slot_free, adv, done, is_data;

  assign slot_free = !out_valid_q || out_o.ready;
  assign adv       = active_q && slot_free;
  assign crc_inv   = ~crc_q;
  assign crc_base  = (step_q == StepMagicLo) ? crcfe_pkg::CrcInit : crc_q;
  assign is_data   = (step_q <= StepLenHi) || (step_q == StepPayload);

  always_comb begin
    unique case (step_q)
      StepMagicLo: byte_sel = cfg_i.magic[7:0];
      StepMagicHi: byte_sel = cfg_i.magic[15:8];
      StepVersion: byte_sel = cfg_i.version;
      StepType:    byte_sel = cmd_q.frame_type;
      StepSeq0:    byte_sel = cmd_q.seq[7:0];
      StepSeq1:    byte_sel = cmd_q.seq[15:8];
      StepSeq2:    byte_sel = cmd_q.seq[23:16];
      StepSeq3:    byte_sel = cmd_q.seq[31:24];
      StepLenLo:   byte_sel = cmd_q.len[7:0];
      StepLenHi:   byte_sel = {3'd0, cmd_q.len[12:8]};
      StepCrc0:    byte_sel = crc_inv[7:0];
      StepCrc1:    byte_sel = crc_inv[15:8];
      StepCrc2:    byte_sel = crc_inv[23:16];
      StepCrc3:    byte_sel = crc_inv[31:24];
      StepPayload: byte_sel = cmd_q.data;
      default:     byte_sel = '0;
    endcase
  end

  always_comb begin
    done      = 1'b0;
    step_next = step_e'(step_q + 4'd1);
    if (step_q == StepLenHi) begin
      if (cmd_q.len == '0) begin
        step_next = StepCrc0;
      end else begin
        done = 1'b1;
      end
    end else if (step_q == StepPayload) begin
      if (cmd_q.last) begin
        step_next = StepCrc0;
      end else begin
        done = 1'b1;
      end
    end else if (step_q == StepCrc3) begin
      done = 1'b1;
    end
  end

  assign pop_o = !fifo_empty_i && (!active_q || (adv && done));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      step_q      <= StepMagicLo;
      crc_q       <= crcfe_pkg::CrcInit;
      out_valid_q <= 1'b0;
      cmd_q       <= '0;
      out_byte_q  <= '0;
      out_eof_q   <= 1'b0;
    end else begin
      if (adv && is_data) begin
        crc_q <= crcfe_pkg::crc_byte(crc_base, byte_sel);
      end
      if (pop_o) begin
        active_q <= 1'b1;
        step_q   <= (pop_data_i.kind == crcfe_pkg::CMD_HDR) ? StepMagicLo : StepPayload;
        cmd_q    <= pop_data_i;
      end else if (adv) begin
        active_q <= !done;
        step_q   <= step_next;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
        out_byte_q  <= byte_sel;
        out_eof_q   <= (step_q == StepCrc3);
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_byte     = out_byte_q;
  assign out_o.end_of_frame = out_eof_q;

  a_step_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> step_q != StepUnused)
    else $error("serializer in unused step");

  a_hdr_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && pop_data_i.kind == crcfe_pkg::CMD_HDR) |=> (active_q && step_q == StepMagicLo))
    else $error("header did not start at magic byte");

  a_eof_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && step_q == StepCrc3) |=> (out_o.valid && out_o.end_of_frame))
    else $error("final CRC byte not marked");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !fifo_empty_i)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== design/crc32_frame_encoder_top.sv =====
// Top level: CRC-32 framed packet encoder.
// Path: command queue, then serializer command register, then output byte register.
// Throughput: one output byte per cycle while commands are queued and the sink is ready;
// a header gives 10 bytes (14 with zero length), a payload byte gives 1 (5 when it closes
// the frame); requests are taken every cycle while the 4-entry command queue has room.
// Reset clears the queue, the frame state, the CRC and the configuration registers.
`default_nettype none

module crc32_frame_encoder_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  crcfe_in_if.sink                          in_i,
  crcfe_out_if.source                       out_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [crcfe_pkg::PaddrW-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  crcfe_pkg::cfg_t cfg;
  crcfe_pkg::cmd_t push_cmd, pop_cmd;
  logic            push, pop, fifo_full, fifo_empty;

  crcfe_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  crcfe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  crcfe_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .pop_data_o  (pop_cmd),
    .full_o      (fifo_full),
    .empty_o     (fifo_empty)
  );

  crcfe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .fifo_empty_i (fifo_empty),
    .pop_data_i   (pop_cmd),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for the CRC-32 frame encoder: random stimulus, byte-stream prediction and checking.
`timescale 1ns / 1ps

module tb;

  localparam logic [crcfe_pkg::PaddrW-1:0] MagicAddr   = {crcfe_pkg::RegMagic, 2'b00};
  localparam logic [crcfe_pkg::PaddrW-1:0] VersionAddr = {crcfe_pkg::RegVersion, 2'b00};
  localparam int unsigned SettleCycles = 16;

  typedef struct {
    crcfe_pkg::op_e op;
    logic [7:0]     frame_type;
    logic [31:0]    seq;
    logic [12:0]    len;
    logic [7:0]     data;
    bit             hold;
  } request_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eof;
  } wire_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [crcfe_pkg::PaddrW-1:0]  paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;

  crcfe_in_if  in_if ();
  crcfe_out_if out_if ();

  crc32_frame_encoder_top u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  request_t   request_q[$];
  wire_byte_t expected_bytes[$];

  logic [15:0]                cfg_magic;
  logic [7:0]                 cfg_version;
  logic [31:0]                crc_state;
  logic [crcfe_pkg::LenW-1:0] bytes_left;
  bit                         frame_open;

  bit in_fire_q;
  bit out_fire_q;
  bit idle_on;
  int in_gap;
  int out_stall;
  int errors;

  always #2 clk_i = ~clk_i;

  function automatic int draw_gap();
    if (!idle_on) return 0;
    return ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 10));
  endfunction

  function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ crcfe_pkg::CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic add_expected(input logic [7:0] b, input logic eof);
    wire_byte_t wb;
    wb.data = b;
    wb.eof  = eof;
    expected_bytes = {expected_bytes, wb};
  endtask

  task automatic add_request(input request_t r);
    request_q = {request_q, r};
  endtask

  task automatic emit_byte(input logic [7:0] b);
    add_expected(b, 1'b0);
    crc_state = crc32_update(crc_state, b);
  endtask

  task automatic close_frame();
    logic [31:0] word;
    word = ~crc_state;
    for (int i = 0; i < 4; i++) begin
      add_expected(word[8*i +: 8], (i == 3));
    end
    frame_open = 1'b0;
    bytes_left = '0;
    crc_state  = crcfe_pkg::CrcInit;
  endtask

  task automatic encode_request(input request_t r);
    logic [crcfe_pkg::LenW-1:0] len;
    if (r.op == crcfe_pkg::OP_HEADER) begin
      len = (r.len > crcfe_pkg::MaxPayload) ? crcfe_pkg::LenW'(crcfe_pkg::MaxPayload) : r.len;
      crc_state = crcfe_pkg::CrcInit;
      emit_byte(cfg_magic[7:0]);
      emit_byte(cfg_magic[15:8]);
      emit_byte(cfg_version);
      emit_byte(r.frame_type);
      for (int i = 0; i < 4; i++) begin
        emit_byte(r.seq[8*i +: 8]);
      end
      emit_byte(len[7:0]);
      emit_byte({3'b000, len[12:8]});
      bytes_left = len;
      frame_open = 1'b1;
      if (len == 0) close_frame();
    end else if (frame_open && bytes_left != 0) begin
      emit_byte(r.data);
      bytes_left--;
      if (bytes_left == 0) close_frame();
    end
  endtask

  // monitor: predict on accepted requests, check accepted bytes
  always @(posedge clk_i) begin
    request_t   r;
    wire_byte_t want;
    if (!rst_ni) begin
      in_fire_q  <= 1'b0;
      out_fire_q <= 1'b0;
    end else begin
      in_fire_q  <= in_if.valid && in_if.ready;
      out_fire_q <= out_if.valid && out_if.ready;
      if (in_if.valid && in_if.ready) begin
        r.op         = crcfe_pkg::op_e'(in_if.operation);
        r.frame_type = in_if.frame_type;
        r.seq        = in_if.sequence_number;
        r.len        = in_if.payload_length;
        r.data       = in_if.payload_byte;
        r.hold       = 1'b0;
        encode_request(r);
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch("unexpected out_byte", out_if.out_byte, 0);
        end else begin
          want = expected_bytes.pop_front();
          if (out_if.out_byte !== want.data) begin
            report_mismatch("out_byte", out_if.out_byte, want.data);
          end
          if (out_if.end_of_frame !== want.eof) begin
            report_mismatch("end_of_frame", out_if.end_of_frame, want.eof);
          end
        end
      end
    end
  end

  // request driver
  always @(negedge clk_i) begin
    request_t r;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_gap = 0;
    end else if (!in_if.valid || in_fire_q) begin
      if (in_gap != 0) begin
        in_gap--;
        in_if.valid <= 1'b0;
      end else if (request_q.size() != 0 &&
                   !(request_q[0].hold && expected_bytes.size() != 0)) begin
        r = request_q.pop_front();
        in_if.valid           <= 1'b1;
        in_if.operation       <= r.op;
        in_if.frame_type      <= r.frame_type;
        in_if.sequence_number <= r.seq;
        in_if.payload_length  <= r.len;
        in_if.payload_byte    <= r.data;
        in_gap = draw_gap();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // byte sink stalls
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b1;
      out_stall = 0;
    end else if (out_fire_q) begin
      out_stall = draw_gap();
      out_if.ready <= (out_stall == 0);
    end else if (out_stall != 0) begin
      out_stall--;
      out_if.ready <= (out_stall == 0);
    end
  end

  task automatic apb_write(input logic [crcfe_pkg::PaddrW-1:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr == MagicAddr) cfg_magic = data[15:0];
    else if (addr == VersionAddr) cfg_version = data[7:0];
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic check_register(input logic [crcfe_pkg::PaddrW-1:0] addr,
                                input logic [31:0] want);
    logic [31:0] got;
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = addr;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    got = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    if (got !== want) report_mismatch("prdata", got, want);
  endtask

  task automatic add_header(input logic [7:0] t, input logic [31:0] s, input logic [12:0] l,
                            input bit hold);
    add_request('{op: crcfe_pkg::OP_HEADER, frame_type: t, seq: s, len: l,
                  data: 8'($urandom), hold: hold});
  endtask

  task automatic add_payload(input logic [7:0] d);
    add_request('{op: crcfe_pkg::OP_PAYLOAD, frame_type: 8'($urandom), seq: $urandom,
                  len: 13'($urandom), data: d, hold: 1'b0});
  endtask

  task automatic add_random_frames(input int count);
    int n;
    int mode;
    int len;
    int sent;
    bit truncate;
    n = 0;
    while (n < count) begin
      mode = $urandom_range(0, 19);
      if (mode == 0) len = $urandom_range(crcfe_pkg::MaxPayload, 8191);
      else if (mode == 1) len = $urandom_range(13, 64);
      else len = $urandom_range(0, 12);
      truncate = (len > 0) && (mode == 0 || $urandom_range(0, 7) == 0);
      if (truncate) sent = $urandom_range(0, (len > 8) ? 8 : len - 1);
      else sent = len;
      add_header(8'($urandom), $urandom, 13'(len), $urandom_range(0, 31) == 0);
      for (int i = 0; i < sent; i++) begin
        add_payload(8'($urandom));
      end
      n += 1 + sent;
      // stray payload after a closed frame is dropped by the block
      if (!truncate && $urandom_range(0, 7) == 0) add_payload(8'($urandom));
    end
  endtask

  task automatic wait_idle();
    while (request_q.size() != 0 || in_if.valid || expected_bytes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [15:0] magic, input logic [7:0] version,
                           input bit idle, input int count);
    apb_write(MagicAddr, {16'd0, magic});
    apb_write(VersionAddr, {24'd0, version});
    check_register(MagicAddr, {16'd0, magic});
    check_register(VersionAddr, {24'd0, version});
    @(posedge clk_i);
    idle_on = idle;
    add_random_frames(count);
    wait_idle();
  endtask

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_ni   = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    in_if.valid           = 1'b0;
    in_if.operation       = crcfe_pkg::OP_HEADER;
    in_if.frame_type      = '0;
    in_if.sequence_number = '0;
    in_if.payload_length  = '0;
    in_if.payload_byte    = '0;
    out_if.ready          = 1'b1;
    cfg_magic   = '0;
    cfg_version = '0;
    crc_state   = crcfe_pkg::CrcInit;
    bytes_left  = '0;
    frame_open  = 1'b0;
    idle_on     = 1'b1;
    errors      = 0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    check_register(MagicAddr, 32'd0);
    check_register(VersionAddr, 32'd0);
    @(posedge clk_i);
    add_payload(8'h5A);
    add_header(8'h00, 32'h0000_0000, 13'd0, 1'b0);
    add_header(8'hFF, 32'hFFFF_FFFF, 13'd0, 1'b0);
    add_header(8'h12, 32'h89AB_CDEF, 13'd3, 1'b0);
    add_payload(8'h00);
    add_payload(8'hFF);
    add_payload(8'hA5);
    add_payload(8'h3C);
    add_header(8'h07, 32'h0000_0001, 13'd5, 1'b0);
    add_payload(8'h11);
    add_payload(8'h22);
    add_header(8'h08, 32'h0000_0002, 13'd1, 1'b1);
    add_payload(8'h33);
    add_header(8'hAA, 32'h5555_5555, 13'h1FFF, 1'b0);
    add_payload(8'h01);
    add_payload(8'h02);
    add_header(8'h55, 32'hAAAA_AAAA, 13'd4097, 1'b0);
    add_payload(8'h80);
    add_header(8'hC3, 32'h0F0F_0F0F, 13'd4096, 1'b0);
    add_header(8'h3C, 32'hF0F0_F0F0, 13'd2, 1'b0);
    add_payload(8'hFE);
    add_payload(8'h7F);
    wait_idle();

    run_phase(16'hFFFF, 8'hFF, 1'b1, 80);
    run_phase(16'h0000, 8'h00, 1'b0, 80);
    run_phase(16'($urandom), 8'($urandom), 1'b1, 80);
    run_phase(16'hA55A, 8'h5A, 1'b1, 80);

    if (expected_bytes.size() != 0) begin
      report_mismatch("bytes never seen", expected_bytes.size(), 0);
    end
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
